// ===== rtl/bhef_pkg.sv =====
package bhef_pkg;

    localparam int TAB_WIDTH = 8;
    localparam int ESC_WIDTH = 4;
    localparam int COL_W     = 17;
    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] REG_FOLD_LENGTH = 2'd0;
    localparam logic [1:0] REG_DROP_UNPRINTABLE = 2'd1;

    // character codes
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h58;

    // back-end emit steps
    localparam logic [2:0] STEP_NL   = 3'd0;
    localparam logic [2:0] STEP_HEAD = 3'd1;
    localparam logic [2:0] STEP_X    = 3'd2;
    localparam logic [2:0] STEP_HI   = 3'd3;
    localparam logic [2:0] STEP_LO   = 3'd4;

    // one classified item, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       esc;   // emit as \Xhh
        logic       fold;  // newline before the item
    } t_desc;

    function automatic logic is_passthrough(input logic [7:0] b);
        return ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else begin
            r = 8'h57 + {4'd0, d};
        end
        return r;
    endfunction

endpackage

// ===== rtl/bhef_front.sv =====
module bhef_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_new_chunk,
    input  logic               i_q_full,
    output logic               o_push,
    output bhef_pkg::t_desc    o_desc
);

    logic [15:0]                r_fold_len;
    logic                       r_drop;
    logic [bhef_pkg::COL_W-1:0] r_col;
    logic [bhef_pkg::COL_W-1:0] n_col;

    logic                       accept;
    logic                       pass;
    logic                       keep;
    logic                       active;
    logic                       fold;
    logic [bhef_pkg::COL_W-1:0] base;
    logic [bhef_pkg::COL_W-1:0] width;
    logic [bhef_pkg::COL_W:0]   sum;
    logic [bhef_pkg::COL_W-1:0] sat;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pass   = bhef_pkg::is_passthrough(i_byte);
        keep   = pass || !r_drop;
        base   = i_new_chunk ? '0 : r_col;
        if (!pass) begin
            width = bhef_pkg::COL_W'(bhef_pkg::ESC_WIDTH);
        end else if (i_byte == bhef_pkg::CH_TAB) begin
            width = bhef_pkg::COL_W'(bhef_pkg::TAB_WIDTH);
        end else begin
            width = bhef_pkg::COL_W'(1);
        end
        sum    = {1'b0, base} + {1'b0, width};
        sat    = sum[bhef_pkg::COL_W] ? bhef_pkg::COL_MAX : sum[bhef_pkg::COL_W-1:0];
        active = (r_fold_len != 16'd0) && keep;
        fold   = active && (sat >= {1'b0, r_fold_len});
        if (!active) begin
            n_col = base;
        end else if (fold) begin
            n_col = '0;
        end else begin
            n_col = sat;
        end
    end

    assign o_push      = accept && keep;
    assign o_desc.data = i_byte;
    assign o_desc.esc  = !pass;
    assign o_desc.fold = fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_len <= '0;
            r_drop     <= 1'b0;
            r_col      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == bhef_pkg::REG_FOLD_LENGTH)) begin
                r_fold_len <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == bhef_pkg::REG_DROP_UNPRINTABLE)) begin
                r_drop <= i_cfg_data[0];
            end
            if (accept) begin
                r_col <= n_col;
            end
        end
    end

endmodule

// ===== rtl/bhef_queue.sv =====
module bhef_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bhef_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pull,
    output logic            o_valid,
    output bhef_pkg::t_desc o_desc
);

    bhef_pkg::t_desc                r_mem [bhef_pkg::QDEPTH];
    logic [bhef_pkg::QPTR_W-1:0]    r_wr;
    logic [bhef_pkg::QPTR_W-1:0]    r_rd;
    logic [bhef_pkg::QCOUNT_W-1:0]  r_count;

    logic do_push;
    logic do_pull;

    assign o_full  = (r_count == bhef_pkg::QCOUNT_W'(bhef_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pull = i_pull && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pull) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pull) begin
                r_count <= r_count + 1'b1;
            end else if (do_pull && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bhef_back.sv =====
module bhef_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  bhef_pkg::t_desc i_q_desc,
    output logic            o_q_pull,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_last
);

    logic            r_valid;
    bhef_pkg::t_desc r_desc;
    logic [2:0]      r_step;

    logic xfer;

    assign o_valid  = r_valid;
    assign xfer     = r_valid && i_ready;
    assign o_last   = (r_step == bhef_pkg::STEP_LO) ||
                      ((r_step == bhef_pkg::STEP_HEAD) && !r_desc.esc);
    assign o_q_pull = i_q_valid && (!r_valid || (xfer && o_last));

    always_comb begin
        case (r_step)
            bhef_pkg::STEP_NL:   o_data = bhef_pkg::CH_NEWLINE;
            bhef_pkg::STEP_HEAD: o_data = r_desc.esc ? bhef_pkg::CH_BACKSLASH : r_desc.data;
            bhef_pkg::STEP_X:    o_data = bhef_pkg::CH_X;
            bhef_pkg::STEP_HI:   o_data = bhef_pkg::hex_digit(r_desc.data[7:4]);
            bhef_pkg::STEP_LO:   o_data = bhef_pkg::hex_digit(r_desc.data[3:0]);
            default:             o_data = bhef_pkg::CH_NEWLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pull) begin
            r_desc <= i_q_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= bhef_pkg::STEP_NL;
        end else if (o_q_pull) begin
            r_valid <= 1'b1;
            r_step  <= i_q_desc.fold ? bhef_pkg::STEP_NL : bhef_pkg::STEP_HEAD;
        end else if (xfer) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

endmodule

// ===== rtl/byte_hex_escape_folder.sv =====
// Path: an accepted byte is written to the queue, then loaded into the emit
//   register, before its first output byte shows, with the output idle.
// Throughput: one output byte per cycle while the output is ready; an item
//   needs 1 to 5 output bytes (none if dropped). Input takes one byte per
//   cycle while the 4-entry queue has room.
// Reset: synchronous active low; clears registers, column count and queue.
module byte_hex_escape_folder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: index 0 fold_length, index 1 drop_unprintable
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] new_chunk
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast    // last_of_run
);

    // front -> queue
    logic            push;
    bhef_pkg::t_desc push_desc;
    logic            q_full;
    // queue -> back
    logic            q_valid;
    bhef_pkg::t_desc q_desc;
    logic            q_pull;

    // Front: classifies each byte, runs the column counter and decides
    // on fold newlines; dropped bytes never reach the queue.
    bhef_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_new_chunk (i_s_axis_tuser),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    // Short descriptor queue decouples the two sides.
    bhef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pull  (q_pull),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    // Back: serializes newline / byte / \Xhh, one transfer per cycle while
    // ready; loads the next item on the last transfer without a bubble.
    bhef_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_q_pull  (q_pull),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== rtl/bhef_checker.sv =====
module bhef_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // stalled output holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // only printable, whitespace or escape characters leave the block
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata >= 8'h20) && (o_m_axis_tdata <= 8'h7E)) ||
            ((o_m_axis_tdata >= 8'h09) && (o_m_axis_tdata <= 8'h0D)))
        else $error("unprintable byte on output");

    // a run continues without a gap until its last transfer
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside an output run");

    // reset empties the block: output idle, input ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not empty after reset");

endmodule

bind byte_hex_escape_folder bhef_checker u_bhef_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
